[design/assert_macros.svh]
// Assertion macros used by the checker file of the timeout table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check with an asynchronous active-low reset.
`define TTWE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("timeout table check failed");

// Check a non-overlapping implication from a condition to a property.
`define TTWE_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("timeout table sequencing check failed");

`endif

[design/ttwe_pkg.sv]
// Shared types and constants for the timeout table with earliest-deadline report.
package ttwe_pkg;

    // Table size and field widths.
    localparam int CAPACITY  = 16;
    localparam int CNT_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PORT_W    = 63;
    localparam int DL_W      = 63;
    localparam int IN_DL_W   = 64;
    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 128;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_APPLY,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Table operation applied to every cell in the same cycle.
    typedef enum logic [1:0] {
        OP_NONE,
        OP_UPDATE,
        OP_INSERT,
        OP_REMOVE
    } op_t;

    // One table entry as held in a cell and as a scan candidate.
    typedef struct packed {
        logic              valid;
        logic [PORT_W-1:0] port;
        logic [DL_W-1:0]   dl;
    } entry_t;

    // Control broadcast from the sequencer to the cells.
    typedef struct packed {
        logic match_en;
        logic apply_en;
        logic scan_en;
        logic out_load;
    } cell_ctl_t;

endpackage

[design/ttwe_cell.sv]
// One table slot: holds an entry, shifts with its neighbors and passes the running minimum.
module ttwe_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ttwe_pkg::cell_ctl_t            ctl,
    input  ttwe_pkg::op_t                  op,
    input  logic [ttwe_pkg::PORT_W-1:0]    in_port,
    input  logic [ttwe_pkg::DL_W-1:0]      in_dl,
    input  ttwe_pkg::entry_t               prev_entry,
    input  ttwe_pkg::entry_t               next_entry,
    input  logic                           after_in,
    output logic                           after_out,
    output ttwe_pkg::entry_t               entry,
    input  ttwe_pkg::entry_t               cand_in,
    output ttwe_pkg::entry_t               cand_out
);

    logic              valid_reg, valid_next;
    logic [ttwe_pkg::PORT_W-1:0] port_reg, port_next;
    logic [ttwe_pkg::DL_W-1:0]   dl_reg, dl_next;
    logic              match_reg, match_next;
    ttwe_pkg::entry_t  cand_reg, cand_next;

    assign entry     = '{valid: valid_reg, port: port_reg, dl: dl_reg};
    assign after_out = after_in | match_reg;
    assign cand_out  = cand_reg;

    // Port compare against the item and the table update for this slot.
    always_comb
    begin
        match_next = match_reg;
        valid_next = valid_reg;
        port_next  = port_reg;
        dl_next    = dl_reg;
        if (ctl.match_en)
        begin
            match_next = valid_reg && (port_reg == in_port);
        end
        if (ctl.apply_en)
        begin
            case (op)
                ttwe_pkg::OP_UPDATE:
                begin
                    if (match_reg)
                    begin
                        dl_next = in_dl;
                    end
                end
                ttwe_pkg::OP_INSERT:
                begin
                    valid_next = prev_entry.valid;
                    port_next  = prev_entry.port;
                    dl_next    = prev_entry.dl;
                end
                ttwe_pkg::OP_REMOVE:
                begin
                    // Slots at and behind the removed entry move up by one.
                    if (after_out)
                    begin
                        valid_next = next_entry.valid;
                        port_next  = next_entry.port;
                        dl_next    = next_entry.dl;
                    end
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    // Running minimum: a valid own entry wins over an empty candidate or on a strictly smaller deadline.
    always_comb
    begin
        cand_next = cand_reg;
        if (ctl.scan_en)
        begin
            if (valid_reg && (!cand_in.valid || (dl_reg < cand_in.dl)))
            begin
                cand_next = entry;
            end
            else
            begin
                cand_next = cand_in;
            end
        end
    end

    // Control bits and the scan candidate are reset; entry payload is not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
            cand_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
            cand_reg  <= cand_next;
        end
    end

    always_ff @(posedge clk)
    begin
        port_reg <= port_next;
        dl_reg   <= dl_next;
    end

endmodule

[design/ttwe_ctrl.sv]
// Sequencer: item handshake, match, apply and scan phases, and the output handshake.
module ttwe_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output ttwe_pkg::cell_ctl_t ctl
);

    ttwe_pkg::state_t             state_reg, state_next;
    logic [ttwe_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                         out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == ttwe_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    // State register, scan counter and output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ttwe_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and per-phase enables.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ctl            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ttwe_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ttwe_pkg::ST_MATCH;
                end
            end
            ttwe_pkg::ST_MATCH:
            begin
                ctl.match_en = 1'b1;
                state_next   = ttwe_pkg::ST_APPLY;
            end
            ttwe_pkg::ST_APPLY:
            begin
                ctl.apply_en = 1'b1;
                cnt_next     = '0;
                state_next   = ttwe_pkg::ST_SCAN;
            end
            ttwe_pkg::ST_SCAN:
            begin
                // The minimum travels one cell per cycle down the row.
                ctl.scan_en = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == ttwe_pkg::CNT_W'(ttwe_pkg::CAPACITY - 1))
                begin
                    state_next = ttwe_pkg::ST_DONE;
                end
            end
            ttwe_pkg::ST_DONE:
            begin
                // Wait until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    ctl.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ttwe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ttwe_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[design/timeout_table_with_earliest_top.sv]
// Top level: a row of table cells with its sequencer and output register.
// Each item passes through the match, update, scan (over all CAPACITY cells), load and idle states
// in that order; a new item is accepted only in the idle state, once the last one is through.
// The result becomes valid when it is loaded and then waits in an output register;
// a busy output register delays the load and so the next acceptance.
// Reset (rst_n, asynchronous, active low) empties the table, clears the output valid and idles the sequencer.
module timeout_table_with_earliest_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0: port_id[62:0], deadline[126:63], zero pad [127].
    input  logic [ttwe_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Fields from bit 0: any_pending[0], earliest_port[63:1],
    // earliest_deadline[126:64], table_full_drop[127].
    output logic [ttwe_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    ttwe_pkg::cell_ctl_t              ctl;
    ttwe_pkg::op_t                    op;
    logic [ttwe_pkg::PORT_W-1:0]      port_reg;
    logic [ttwe_pkg::IN_DL_W-1:0]     dl_reg;
    logic                             drop_reg, drop_next;
    logic [ttwe_pkg::M_TDATA_W-1:0]   out_reg;
    ttwe_pkg::entry_t                 head_entry;
    ttwe_pkg::entry_t                 cells [ttwe_pkg::CAPACITY];
    ttwe_pkg::entry_t                 cands [ttwe_pkg::CAPACITY];
    logic [ttwe_pkg::CAPACITY:0]      after;
    logic                             hit, remove, full;

    ttwe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .ctl       (ctl)
    );

    // Item capture on acceptance.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            port_reg <= s_axis_tdata[ttwe_pkg::PORT_W-1:0];
            dl_reg   <= s_axis_tdata[ttwe_pkg::PORT_W +: ttwe_pkg::IN_DL_W];
        end
    end

    assign head_entry = '{valid: 1'b1, port: port_reg, dl: dl_reg[ttwe_pkg::DL_W-1:0]};
    assign after[0]   = 1'b0;

    // The row of cells; each one sees its two neighbors.
    for (genvar i = 0; i < ttwe_pkg::CAPACITY; i++)
    begin : g_cell
        ttwe_pkg::entry_t prev_e, next_e, cand_i;
        if (i == 0)
        begin : g_head
            assign prev_e = head_entry;
            assign cand_i = '0;
        end
        else
        begin : g_body
            assign prev_e = cells[i-1];
            assign cand_i = cands[i-1];
        end
        if (i == ttwe_pkg::CAPACITY - 1)
        begin : g_tail
            assign next_e = '0;
        end
        else
        begin : g_mid
            assign next_e = cells[i+1];
        end

        ttwe_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .op         (op),
            .in_port    (port_reg),
            .in_dl      (dl_reg[ttwe_pkg::DL_W-1:0]),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .after_in   (after[i]),
            .after_out  (after[i+1]),
            .entry      (cells[i]),
            .cand_in    (cand_i),
            .cand_out   (cands[i])
        );
    end

    // Decide the table operation from the match result.
    assign hit    = after[ttwe_pkg::CAPACITY];
    assign remove = dl_reg[ttwe_pkg::IN_DL_W-1];
    assign full   = cells[ttwe_pkg::CAPACITY-1].valid;

    always_comb
    begin
        op        = ttwe_pkg::OP_NONE;
        drop_next = drop_reg;
        if (hit)
        begin
            op = remove ? ttwe_pkg::OP_REMOVE : ttwe_pkg::OP_UPDATE;
        end
        else if (!remove && !full)
        begin
            op = ttwe_pkg::OP_INSERT;
        end
        if (ctl.apply_en)
        begin
            drop_next = !hit && !remove && full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_reg <= 1'b0;
        end
        else
        begin
            drop_reg <= drop_next;
        end
    end

    // Output register, loaded from the last cell's candidate.
    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            if (cands[ttwe_pkg::CAPACITY-1].valid)
            begin
                out_reg <= {drop_reg, cands[ttwe_pkg::CAPACITY-1].dl,
                            cands[ttwe_pkg::CAPACITY-1].port, 1'b1};
            end
            else
            begin
                out_reg <= {drop_reg, {(ttwe_pkg::M_TDATA_W-1){1'b0}}};
            end
        end
    end

    assign m_axis_tdata = out_reg;

endmodule

[design/ttwe_checker.sv]
// Port-level checks for the timeout table, bound to the top level.
`include "assert_macros.svh"

module ttwe_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [127:0] s_axis_tdata,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);

    // A stalled result keeps its contents.
    `TTWE_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // An empty table reports zero port and deadline.
    `TTWE_ASSERT(a_empty_zero, clk, rst_n, (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[126:1] == 126'd0))

    // A dropped insert means the table is full, hence not empty.
    `TTWE_ASSERT(a_drop_nonempty, clk, rst_n, (m_axis_tvalid && m_axis_tdata[127]) |-> m_axis_tdata[0])

    // The block works on one item at a time.
    `TTWE_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind timeout_table_with_earliest_top ttwe_checker u_ttwe_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[tb/tb_timeout_table_with_earliest_top.sv]
// Self-checking stream testbench for the timeout table with earliest-deadline report.
module tb_timeout_table_with_earliest_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [62:0] MAX63 = 63'h7FFF_FFFF_FFFF_FFFF;

    // Expected summary that follows one table update.
    typedef struct {
        logic        any_pending;
        logic [62:0] earliest_port;
        logic [62:0] earliest_deadline;
        logic        table_full_drop;
    } pending_summary_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [ttwe_pkg::S_TDATA_W-1:0] s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [ttwe_pkg::M_TDATA_W-1:0] m_axis_tdata;

    // Shadow copy of the timeout table, head at slot 0.
    logic [62:0] shadow_port [ttwe_pkg::CAPACITY];
    logic [62:0] shadow_deadline [ttwe_pkg::CAPACITY];
    int          shadow_count;

    pending_summary_t expected_summaries[$];
    logic [62:0]      hot_ports [20];

    int  mismatch_count;
    int  items_sent;
    int  results_checked;
    int  drops_predicted;
    int  removes_sent;
    int  cycle_count;
    bit  src_idle_en;
    bit  sink_idle_en;

    timeout_table_with_earliest_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock generation.
    always #5 clk = ~clk;

    // Run watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout_table_with_earliest_top regression: fail");
            $finish;
        end
    end

    // Apply one update to the shadow table and return the summary it should produce.
    function automatic pending_summary_t apply_timeout_update(logic [62:0] port,
                                                              logic [63:0] deadline);
        pending_summary_t s;
        int hit;
        int i;
        hit = -1;
        s.table_full_drop = 1'b0;
        for (i = 0; i < shadow_count; i++)
        begin
            if (hit < 0 && shadow_port[i] == port)
                hit = i;
        end
        if (hit >= 0)
        begin
            if (deadline[63])
            begin
                // Close the gap left by the removed entry.
                for (i = hit; i < shadow_count - 1; i++)
                begin
                    shadow_port[i] = shadow_port[i + 1];
                    shadow_deadline[i] = shadow_deadline[i + 1];
                end
                shadow_count--;
            end
            else
                shadow_deadline[hit] = deadline[62:0];
        end
        else if (!deadline[63])
        begin
            if (shadow_count >= ttwe_pkg::CAPACITY)
                s.table_full_drop = 1'b1;
            else
            begin
                // New entries go to the head and push the rest back.
                for (i = shadow_count; i > 0; i--)
                begin
                    shadow_port[i] = shadow_port[i - 1];
                    shadow_deadline[i] = shadow_deadline[i - 1];
                end
                shadow_port[0] = port;
                shadow_deadline[0] = deadline[62:0];
                shadow_count++;
            end
        end
        // Scan from the head; a strict compare keeps the entry nearest the head on ties.
        s.any_pending = (shadow_count > 0);
        s.earliest_port = '0;
        s.earliest_deadline = '0;
        for (i = 0; i < shadow_count; i++)
        begin
            if (i == 0 || shadow_deadline[i] < s.earliest_deadline)
            begin
                s.earliest_port = shadow_port[i];
                s.earliest_deadline = shadow_deadline[i];
            end
        end
        return s;
    endfunction

    function automatic logic [62:0] random_63();
        return 63'({$urandom, $urandom});
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH result %0d: %s", $realtime, results_checked, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string field, logic [62:0] got, logic [62:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", field, got, want));
    endtask

    // Send one item: an optional idle burst, then hold tvalid until accepted.
    task automatic push_timeout_item(logic [62:0] port, logic [63:0] deadline);
        int gap;
        @(negedge clk);
        gap = 0;
        if (src_idle_en && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 12);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, deadline, port};
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_summaries.push_back(apply_timeout_update(port, deadline));
        if (expected_summaries[$].table_full_drop)
            drops_predicted++;
        if (deadline[63])
            removes_sent++;
        items_sent++;
    endtask

    // Result checker: compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        pending_summary_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_summaries.size() == 0)
                report_mismatch("result item with no expectation pending");
            else
            begin
                want = expected_summaries.pop_front();
                check_field("any_pending", {62'd0, m_axis_tdata[0]}, {62'd0, want.any_pending});
                check_field("earliest_port", m_axis_tdata[63:1], want.earliest_port);
                check_field("earliest_deadline", m_axis_tdata[126:64], want.earliest_deadline);
                check_field("table_full_drop", {62'd0, m_axis_tdata[127]},
                            {62'd0, want.table_full_drop});
                results_checked++;
            end
        end
    end

    // Result sink: ready drops in random bursts while stalls are enabled.
    initial
    begin
        int stall_left;
        m_axis_tready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (sink_idle_en && stall_left == 0 && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 12);
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Removes on an empty table, including the most negative deadline.
    task automatic test_empty_table();
        push_timeout_item(63'd5, 64'hFFFF_FFFF_FFFF_FFFF);
        push_timeout_item(63'd0, 64'h8000_0000_0000_0000);
    endtask

    // Extreme ports and deadlines, ties, a head removal and a miss.
    task automatic test_extremes_and_ties();
        push_timeout_item(MAX63, {1'b0, MAX63});
        push_timeout_item(63'd0, 64'd0);
        push_timeout_item(63'd7, 64'd0);
        push_timeout_item(MAX63, 64'd0);
        push_timeout_item(63'd7, 64'hFFFF_FFFF_FFFF_FFFF);
        push_timeout_item(63'd9, -64'sd5);
    endtask

    // Fill to capacity, drop a new port, update in place while full, remove the tail.
    task automatic test_full_table();
        int i;
        for (i = 0; i < ttwe_pkg::CAPACITY - 2; i++)
            push_timeout_item(63'd100 + i, 64'd1000 - i);
        push_timeout_item(63'd200, 64'd3);
        push_timeout_item(63'd105, 64'd1);
        push_timeout_item(MAX63, {1'b1, random_63()});
    endtask

    // Random traffic in episodes whose insert bias swings the fill level up and down.
    task automatic test_random_traffic(int n_items, bit with_idle);
        int n;
        int insert_pct;
        int r;
        logic [62:0] port;
        logic [63:0] deadline;
        src_idle_en = with_idle;
        sink_idle_en = with_idle;
        insert_pct = 50;
        for (n = 0; n < n_items; n++)
        begin
            if (n % 40 == 0)
                insert_pct = 30 + 20 * $urandom_range(0, 3);
            r = $urandom_range(0, 99);
            if (r < 75)
                port = hot_ports[$urandom_range(0, 19)];
            else if (r < 85 && shadow_count > 0)
                port = shadow_port[$urandom_range(0, shadow_count - 1)];
            else
                port = random_63();
            if ($urandom_range(0, 99) < insert_pct)
            begin
                case ($urandom_range(0, 7))
                    0, 1: deadline = 64'($urandom_range(0, 7));
                    2: deadline = {1'b0, MAX63};
                    default: deadline = {1'b0, random_63()};
                endcase
            end
            else
            begin
                // Most removals aim at a port that is present.
                if (shadow_count > 0 && $urandom_range(0, 3) != 0)
                    port = shadow_port[$urandom_range(0, shadow_count - 1)];
                case ($urandom_range(0, 7))
                    0: deadline = 64'hFFFF_FFFF_FFFF_FFFF;
                    1: deadline = 64'h8000_0000_0000_0000;
                    default: deadline = {1'b1, random_63()};
                endcase
            end
            push_timeout_item(port, deadline);
        end
    endtask

    initial
    begin
        int i;
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        mismatch_count = 0;
        items_sent = 0;
        results_checked = 0;
        drops_predicted = 0;
        removes_sent = 0;
        cycle_count = 0;
        shadow_count = 0;
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        hot_ports[0] = '0;
        hot_ports[1] = MAX63;
        for (i = 2; i < 20; i++)
            hot_ports[i] = random_63();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_extremes_and_ties();
        test_full_table();
        test_random_traffic(1000, 1'b1);
        test_random_traffic(500, 1'b0);

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_summaries.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d items (%0d removals), checked %0d results.",
                 items_sent, removes_sent, results_checked);
        $display("Full-table drops expected: %0d; mismatches: %0d.",
                 drops_predicted, mismatch_count);
        if (mismatch_count == 0)
            $display("timeout_table_with_earliest_top regression: pass");
        else
            $display("timeout_table_with_earliest_top regression: fail");
        $finish;
    end

endmodule
